// ----- design/ostb_pkg.sv -----
// Shared types and constants for the one-shot timer bank.
`timescale 1ns / 1ps

package ostb_pkg;

    // Field widths fixed by the request and result formats
    localparam int REQ_W        = 3;
    localparam int SLOT_FIELD_W = 4;
    localparam int TICK_W       = 32;

    // Default bank size
    localparam int NUM_SLOTS_DEF = 16;

    // Request codes; the two spare codes are acknowledged with no effect
    typedef enum logic [REQ_W-1:0] {
        REQ_TICK   = 3'd0,
        REQ_ADD    = 3'd1,
        REQ_REMOVE = 3'd2,
        REQ_SETEXP = 3'd3,
        REQ_START  = 3'd4,
        REQ_STOP   = 3'd5
    } t_req;

    // One result item as held in the output register
    typedef struct packed {
        logic                    fired;
        logic [SLOT_FIELD_W-1:0] fired_slot;
        logic [TICK_W-1:0]       tick_now;
        logic                    last;
    } t_result;

endpackage

// ----- design/ostb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ostb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/one_shot_timer_bank.sv -----
// Top level: one-shot timer bank, expiries in RAM, masks and tick in flops.
// Add/remove/set expiry/stop/spare codes give their result the cycle after the
// input transfer; start first passes through the start state for the expiry read from RAM.
// Tick walks one slot per cycle unless a firing waits on a full output; a flush
// state then gives the last result. One request at a time.
// Reset (synchronous, active low) clears tick, masks and control; the expiry
// RAM is not cleared and is only meaningful once written.
`timescale 1ns / 1ps

module one_shot_timer_bank
    import ostb_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // request channel
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [REQ_W-1:0]        i_req_type,
    input  logic [SLOT_FIELD_W-1:0] i_slot,
    input  logic [TICK_W-1:0]       i_expiry_value,
    input  logic                    i_notify,
    // result channel
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic                    o_fired,
    output logic [SLOT_FIELD_W-1:0] o_fired_slot,
    output logic [TICK_W-1:0]       o_tick_now,
    output logic                    o_last
);

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_WALK,
        S_FLUSH
    } t_state;

    t_state               r_state;
    logic [TICK_W-1:0]    r_tick;
    logic [NUM_SLOTS-1:0] r_armed;
    logic [NUM_SLOTS-1:0] r_member;
    logic [NUM_SLOTS-1:0] r_notify;
    logic [SLOT_W-1:0]    r_idx;
    logic                 r_pend_v;
    logic [SLOT_W-1:0]    r_pend_slot;
    logic                 r_out_valid;
    t_result              r_out;

    logic                 w_in_xfer;
    logic                 w_out_free;
    logic                 w_in_range;
    logic [SLOT_W-1:0]    w_slot_idx;
    logic                 w_hit;
    logic                 w_nhit;
    logic                 w_stall;
    logic                 w_walk_end;
    logic                 w_ram_we;
    logic [SLOT_W-1:0]    w_ram_raddr;
    logic [TICK_W-1:0]    w_ram_wdata;
    logic [TICK_W-1:0]    w_ram_rdata;

    // Handshake: output slot is free if empty or draining this cycle
    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && w_out_free;
    assign w_in_xfer  = i_in_valid && o_in_ready;

    // Addressed slot
    assign w_in_range = (int'(i_slot) < NUM_SLOTS);
    assign w_slot_idx = SLOT_W'(i_slot);

    // Walk check on the slot whose expiry is on the RAM read port
    assign w_hit      = r_member[r_idx] && r_armed[r_idx] && (w_ram_rdata <= r_tick);
    assign w_nhit     = w_hit && r_notify[r_idx];
    assign w_stall    = w_nhit && r_pend_v && !w_out_free;
    assign w_walk_end = (r_idx == SLOT_W'(NUM_SLOTS - 1));

    // Expiry RAM write: add clears, set expiry loads
    assign w_ram_we    = w_in_xfer && w_in_range &&
                         ((i_req_type == REQ_ADD) || (i_req_type == REQ_SETEXP));
    assign w_ram_wdata = (i_req_type == REQ_ADD) ? '0 : i_expiry_value;

    // Expiry RAM read address: request slot, walk start, or walk look-ahead
    always_comb begin
        w_ram_raddr = r_idx;
        if (r_state == S_IDLE) begin
            w_ram_raddr = (i_req_type == REQ_TICK) ? '0 : w_slot_idx;
        end else if (r_state == S_WALK && !w_stall) begin
            w_ram_raddr = r_idx + 1'b1;
        end
    end

    ostb_ram #(
        .WIDTH (TICK_W),
        .DEPTH (NUM_SLOTS)
    ) u_expiry_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_slot_idx),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // Sequencer, slot masks, tick counter and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tick      <= '0;
            r_armed     <= '0;
            r_member    <= '0;
            r_notify    <= '0;
            r_idx       <= '0;
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_xfer && (i_req_type == REQ_TICK)) begin
                        // no ack here: the walk reports
                        r_out_valid <= 1'b0;
                        r_tick      <= r_tick + 1'b1;
                        r_idx       <= '0;
                        r_pend_v    <= 1'b0;
                        r_state     <= S_WALK;
                    end else if (w_in_xfer && w_in_range && (i_req_type == REQ_START)) begin
                        // ack after the expiry read
                        r_out_valid <= 1'b0;
                        r_idx       <= w_slot_idx;
                        r_state     <= S_START;
                    end else if (w_in_xfer) begin
                        r_out_valid      <= 1'b1;
                        r_out.fired      <= 1'b0;
                        r_out.fired_slot <= '0;
                        r_out.tick_now   <= r_tick;
                        r_out.last       <= 1'b1;
                        if (w_in_range) begin
                            case (i_req_type)
                                REQ_ADD: begin
                                    r_armed[w_slot_idx]  <= 1'b0;
                                    r_member[w_slot_idx] <= 1'b1;
                                    r_notify[w_slot_idx] <= i_notify;
                                end
                                REQ_REMOVE: r_member[w_slot_idx] <= 1'b0;
                                REQ_STOP:   r_armed[w_slot_idx] <= 1'b0;
                                default: ;
                            endcase
                        end
                    end else if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                    end
                end
                S_START: begin
                    r_armed[r_idx] <= (w_ram_rdata > r_tick);
                    r_out_valid      <= 1'b1;
                    r_out.fired      <= 1'b0;
                    r_out.fired_slot <= '0;
                    r_out.tick_now   <= r_tick;
                    r_out.last       <= 1'b1;
                    r_state          <= S_IDLE;
                end
                S_WALK: begin
                    if (!w_stall) begin
                        if (w_hit) begin
                            r_armed[r_idx] <= 1'b0;
                        end
                        if (w_nhit) begin
                            r_pend_v    <= 1'b1;
                            r_pend_slot <= r_idx;
                        end
                        if (w_walk_end) begin
                            r_state <= S_FLUSH;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                    // earlier firing is known not to be the last
                    if (!w_stall && w_nhit && r_pend_v) begin
                        r_out_valid      <= 1'b1;
                        r_out.fired      <= 1'b1;
                        r_out.fired_slot <= SLOT_FIELD_W'(r_pend_slot);
                        r_out.tick_now   <= r_tick;
                        r_out.last       <= 1'b0;
                    end else if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                    end
                end
                S_FLUSH: begin
                    if (w_out_free) begin
                        r_out_valid      <= 1'b1;
                        r_out.fired      <= r_pend_v;
                        r_out.fired_slot <= r_pend_v ? SLOT_FIELD_W'(r_pend_slot) : '0;
                        r_out.tick_now   <= r_tick;
                        r_out.last       <= 1'b1;
                        r_pend_v         <= 1'b0;
                        r_state          <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_fired      = r_out.fired;
    assign o_fired_slot = r_out.fired_slot;
    assign o_tick_now   = r_out.tick_now;
    assign o_last       = r_out.last;

    // Acknowledgements carry slot zero and close their request
    a_ack_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_fired) |-> (o_last && (o_fired_slot == '0)))
        else $error("acknowledgement result malformed");

    // A tick transfer bumps the counter and starts the walk at slot zero
    a_tick_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && (i_req_type == REQ_TICK)) |=>
            ((r_state == S_WALK) && (r_idx == '0) && (r_tick == $past(r_tick) + 1'b1)))
        else $error("tick did not start the walk");

    // A stalled firing never overwrites a result still waiting
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> ($stable(r_out) && o_out_valid))
        else $error("waiting result overwritten");

    // The walk ends with no pending firing left behind
    a_flush_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_v)
        else $error("pending firing left after walk");

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the one-shot timer bank: random requests, predicted results.
`timescale 1ns / 1ps

module tb;
    import ostb_pkg::*;

    localparam int BANK_SLOTS = NUM_SLOTS_DEF;
    localparam int MAX_FIRINGS = 16;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 3 * BANK_SLOTS;

    // Spare request codes: acknowledged, no effect
    localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [REQ_W-1:0]        req_type;
        logic [SLOT_FIELD_W-1:0] slot;
        logic [TICK_W-1:0]       expiry_value;
        logic                    notify;
    } t_request;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic [REQ_W-1:0]        i_req_type = '0;
    logic [SLOT_FIELD_W-1:0] i_slot = '0;
    logic [TICK_W-1:0]       i_expiry_value = '0;
    logic                    i_notify = 1'b0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic                    o_fired;
    logic [SLOT_FIELD_W-1:0] o_fired_slot;
    logic [TICK_W-1:0]       o_tick_now;
    logic                    o_last;

    one_shot_timer_bank #(.NUM_SLOTS(BANK_SLOTS)) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_slot         (i_slot),
        .i_expiry_value (i_expiry_value),
        .i_notify       (i_notify),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_fired        (o_fired),
        .o_fired_slot   (o_fired_slot),
        .o_tick_now     (o_tick_now),
        .o_last         (o_last)
    );

    always #10 i_clk = ~i_clk;

    // Stimulus and expectation stores
    t_request pending_requests[$];
    t_result  expected_results[$];
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;
    int       mismatch_count = 0;
    int       quiet_cycles = 0;

    // Predicted bank state
    logic [TICK_W-1:0]     tick_model;
    logic [TICK_W-1:0]     expiry_model [BANK_SLOTS];
    logic [BANK_SLOTS-1:0] armed_model;
    logic [BANK_SLOTS-1:0] member_model;
    logic [BANK_SLOTS-1:0] notify_model;

    // Generator view: tick count, which slots hold a written expiry and which are members
    logic [TICK_W-1:0]     gen_ticks = '0;
    logic [BANK_SLOTS-1:0] gen_written = '0;
    logic [BANK_SLOTS-1:0] gen_member = '0;
    int                    queued_count = 0;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("%0t mismatch: %s", $time, what);
    endtask

    // Apply one accepted request to the predicted state, queue its results
    task automatic apply_request(input t_request rq);
        t_result hits[$];
        t_result r;
        if (rq.req_type == REQ_TICK) begin
            tick_model = tick_model + 1'b1;
            for (int s = 0; s < BANK_SLOTS; s++) begin
                if (member_model[s] && armed_model[s] && expiry_model[s] <= tick_model) begin
                    armed_model[s] = 1'b0;
                    if (notify_model[s] && hits.size() < MAX_FIRINGS) begin
                        r = '{fired: 1'b1, fired_slot: SLOT_FIELD_W'(s),
                              tick_now: tick_model, last: 1'b0};
                        hits.push_back(r);
                    end
                end
            end
        end else if (int'(rq.slot) < BANK_SLOTS) begin
            case (rq.req_type)
                REQ_ADD: begin
                    expiry_model[rq.slot] = '0;
                    armed_model[rq.slot]  = 1'b0;
                    member_model[rq.slot] = 1'b1;
                    notify_model[rq.slot] = rq.notify;
                end
                REQ_REMOVE: member_model[rq.slot] = 1'b0;
                REQ_SETEXP: expiry_model[rq.slot] = rq.expiry_value;
                REQ_START:  armed_model[rq.slot] = expiry_model[rq.slot] > tick_model;
                REQ_STOP:   armed_model[rq.slot] = 1'b0;
                default: ;
            endcase
        end
        // No notifying firing: a single acknowledgement
        if (hits.size() == 0) begin
            r = '{fired: 1'b0, fired_slot: '0, tick_now: tick_model, last: 1'b0};
            hits.push_back(r);
        end
        hits[hits.size()-1].last = 1'b1;
        foreach (hits[k]) expected_results.push_back(hits[k]);
    endtask

    task automatic queue_request(input logic [REQ_W-1:0] code, input int slot,
                                 input logic [TICK_W-1:0] ev, input logic nt);
        t_request rq;
        rq = '{req_type: code, slot: SLOT_FIELD_W'(slot), expiry_value: ev, notify: nt};
        pending_requests.push_back(rq);
        queued_count++;
        case (code)
            REQ_TICK:   gen_ticks = gen_ticks + 1'b1;
            REQ_ADD: begin
                gen_written[slot] = 1'b1;
                gen_member[slot]  = 1'b1;
            end
            REQ_REMOVE: gen_member[slot] = 1'b0;
            REQ_SETEXP: gen_written[slot] = 1'b1;
            default: ;
        endcase
    endtask

    // Mostly arm sequences and ticks with random content, the rest noise
    task automatic queue_random_traffic(input int count);
        int target;
        int pick;
        int s;
        target = queued_count + count;
        while (queued_count < target) begin
            pick = $urandom_range(0, 99);
            s = $urandom_range(0, BANK_SLOTS - 1);
            if (pick < 28) begin
                queue_request(REQ_TICK, s, $urandom, 1'($urandom));
            end else if (pick < 55) begin
                if (!gen_member[s] || $urandom_range(0, 3) == 0)
                    queue_request(REQ_ADD, s, $urandom, $urandom_range(0, 3) != 0);
                if ($urandom_range(0, 9) == 0)
                    queue_request(REQ_SETEXP, s, gen_ticks, 1'($urandom));
                else
                    queue_request(REQ_SETEXP, s, gen_ticks + $urandom_range(1, 5),
                                  1'($urandom));
                queue_request(REQ_START, s, $urandom, 1'($urandom));
            end else if (pick < 67) begin
                queue_request(REQ_ADD, s, $urandom, 1'($urandom));
            end else if (pick < 73) begin
                queue_request(REQ_REMOVE, s, $urandom, 1'($urandom));
            end else if (pick < 79) begin
                queue_request(REQ_STOP, s, $urandom, 1'($urandom));
            end else if (pick < 85) begin
                queue_request(REQ_SETEXP, s, $urandom, 1'($urandom));
            end else if (pick < 93) begin
                // never start a slot whose expiry was never written
                if (!gen_written[s])
                    queue_request(REQ_SETEXP, s, $urandom, 1'($urandom));
                queue_request(REQ_START, s, $urandom, 1'($urandom));
            end else begin
                queue_request(pick[0] ? REQ_SPARE_HI : REQ_SPARE_LO, s, $urandom,
                              1'($urandom));
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_requests.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(negedge i_clk);
    endtask

    // Request driver: predicts on each transfer, then offers the next item
    always @(posedge i_clk) begin : drive_requests
        t_request nxt;
        if (!i_rst_n) begin
            i_in_valid   <= 1'b0;
            tick_model   = '0;
            armed_model  = '0;
            member_model = '0;
            notify_model = '0;
            foreach (expiry_model[k]) expiry_model[k] = '0;
        end else begin
            if (i_in_valid && o_in_ready)
                apply_request({i_req_type, i_slot, i_expiry_value, i_notify});
            if (!i_in_valid || o_in_ready) begin
                if (pending_requests.size() != 0 &&
                    $urandom_range(0, 99) >= send_idle_pct) begin
                    nxt = pending_requests.pop_front();
                    i_in_valid     <= 1'b1;
                    i_req_type     <= nxt.req_type;
                    i_slot         <= nxt.slot;
                    i_expiry_value <= nxt.expiry_value;
                    i_notify       <= nxt.notify;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each transfer with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result fired=%0b slot=%0d tick=%0d",
                                              o_fired, o_fired_slot, o_tick_now));
                end else begin
                    want = expected_results.pop_front();
                    if (o_fired !== want.fired)
                        report_mismatch($sformatf("fired %0b, want %0b", o_fired, want.fired));
                    if (o_fired_slot !== want.fired_slot)
                        report_mismatch($sformatf("fired_slot %0d, want %0d",
                                                  o_fired_slot, want.fired_slot));
                    if (o_tick_now !== want.tick_now)
                        report_mismatch($sformatf("tick_now %0d, want %0d",
                                                  o_tick_now, want.tick_now));
                    if (o_last !== want.last)
                        report_mismatch($sformatf("last %0b, want %0b", o_last, want.last));
                end
            end
            i_out_ready <= $urandom_range(0, 99) >= recv_idle_pct;
        end
    end

    // Watchdog: too long without any transfer ends the run
    always @(posedge i_clk) begin : watchdog
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        send_idle_pct = 25;
        recv_idle_pct = 87;

        // Directed: two notifying firings in one tick, a silent one, start at
        // expiry equal to tick, spare codes, requests on unregistered slots
        queue_request(REQ_TICK, 0, 32'hFFFF_FFFF, 1'b1);
        queue_request(REQ_ADD, 0, 32'hFFFF_FFFF, 1'b1);
        queue_request(REQ_ADD, 3, 32'h0, 1'b1);
        queue_request(REQ_ADD, 15, 32'h5A5A_A5A5, 1'b0);
        queue_request(REQ_ADD, 5, 32'hA5A5_5A5A, 1'b1);
        queue_request(REQ_SETEXP, 0, 32'd2, 1'b0);
        queue_request(REQ_SETEXP, 3, 32'd2, 1'b1);
        queue_request(REQ_SETEXP, 15, 32'd2, 1'b0);
        queue_request(REQ_SETEXP, 5, 32'hFFFF_FFFF, 1'b1);
        queue_request(REQ_START, 0, 32'h0, 1'b0);
        queue_request(REQ_START, 3, 32'h0, 1'b1);
        queue_request(REQ_START, 15, 32'hFFFF_FFFF, 1'b0);
        queue_request(REQ_START, 5, 32'h0, 1'b1);
        queue_request(REQ_TICK, 15, 32'h0, 1'b0);
        queue_request(REQ_START, 0, 32'hFFFF_FFFF, 1'b1);
        queue_request(REQ_STOP, 5, 32'h1234_5678, 1'b0);
        queue_request(REQ_TICK, 7, 32'h8765_4321, 1'b1);
        queue_request(REQ_SPARE_LO, 10, $urandom, 1'b1);
        queue_request(REQ_SPARE_HI, 6, $urandom, 1'b0);
        queue_request(REQ_REMOVE, 3, 32'h0, 1'b0);
        queue_request(REQ_SETEXP, 3, 32'd4, 1'b0);
        queue_request(REQ_START, 3, 32'h0, 1'b0);
        queue_request(REQ_SETEXP, 9, 32'h0, 1'b1);
        queue_request(REQ_START, 9, 32'h0, 1'b1);
        queue_request(REQ_TICK, 9, 32'h0, 1'b0);
        queue_request(REQ_ADD, 5, 32'h0, 1'b0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_random_traffic(52);
        wait_drained();

        send_idle_pct = 87;
        recv_idle_pct = 25;
        queue_random_traffic(52);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_traffic(52);
        wait_drained();

        // let any stray result surface
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
